// ===== src/amdfs_pkg.sv =====
package amdfs_pkg;

    // Widths of the item fields and of the configuration registers.
    localparam int VERTEX_W    = 5;
    localparam int COUNT_W     = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 1;

    // Command carried in the input tuser.
    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTED     = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 6'd1;
    localparam logic               DIRECTED_RST     = 1'b1;

endpackage

// ===== src/amdfs_ram.sv =====
module amdfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/amdfs_scan.sv =====
module amdfs_scan #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]         cand,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] index
);

    // Priority encoder: the lowest set candidate bit wins.
    always_comb begin
        found = 1'b0;
        index = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found = 1'b1;
                index = ($clog2(WIDTH))'(i);
            end
        end
    end

endmodule

// ===== src/adjacency_matrix_dfs_order.sv =====
// Depth-first walk over a graph kept as a bit adjacency matrix in a one-row-per-vertex
// RAM. An item with tuser at 0 writes one edge (and its mirror when the graph is set to
// undirected); it gives no result and keeps the block busy while each row is read,
// modified and written back through the RAM, the mirror row after the first.
// An item with tuser at 1 walks vertices 0 to vertex_count-1 and sends one item per
// vertex in visiting order, tuser marking the root of each tree and tlast the final one.
// A walk probes the roots in turn and reads the row of the vertex on top of the stack
// after each push and each pop that leaves a vertex on it, and the scan picks the lowest
// unvisited neighbour from the whole row at once. Results leave through a one-item
// pending stage and an output register, and the walk waits only when both are full.
// The matrix reads as empty after reset through per-row valid bits, so no clearing
// pass is needed.
module adjacency_matrix_dfs_order
    import amdfs_pkg::*;
#(
    parameter int MAX_VERTICES = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]     cfg_wdata,
    // Input items.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // from_vertex[4:0], to_vertex[9:5], edge_present[10]
    input  logic                   s_tuser,  // cmd
    // Result items.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // visited_vertex[4:0]
    output logic                   m_tuser,  // new_tree
    output logic                   m_tlast
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_E_RD = 3'd1;
    localparam logic [2:0] S_E_WR = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_END  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [COUNT_W-1:0]     vertex_count_reg;
    logic                   directed_reg;

    logic [VERTEX_W-1:0]    ew_from_reg, ew_to_reg;
    logic                   ew_set_reg, ew_mirror_reg, ew_phase_reg;

    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    rd_valid_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [VW-1:0]           stack_reg [MAX_VERTICES];
    logic [CW-1:0]           depth_reg;
    logic [CW-1:0]           root_reg;

    logic                    pend_valid_reg;
    logic [VW-1:0]           pend_vertex_reg;
    logic                    pend_root_reg;

    logic                    m_valid_reg;
    logic [VERTEX_W-1:0]     m_vertex_reg;
    logic                    m_new_tree_reg;
    logic                    m_last_reg;

    logic                    in_acc;
    logic                    in_range;
    logic [CW-1:0]           count;
    logic [MAX_VERTICES-1:0] count_mask;
    logic [VW-1:0]           top_vertex;
    logic [VW-1:0]           ew_row, ew_bit;
    logic [VW-1:0]           ram_raddr;
    logic [MAX_VERTICES-1:0] ram_rdata, row_cur, row_new, cand;
    logic                    ram_we;
    logic                    found;
    logic [VW-1:0]           scan_idx;
    logic                    out_free, emit_ok;
    logic                    root_open, root_visit, nb_visit, pop, emit, end_push;
    logic [VW-1:0]           emit_vertex;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_range = (int'(s_tdata[4:0]) < MAX_VERTICES) && (int'(s_tdata[9:5]) < MAX_VERTICES);

    // Vertex count in use, saturated to the matrix size, and its column mask.
    always_comb begin
        if (int'(vertex_count_reg) > MAX_VERTICES) begin
            count = CW'(MAX_VERTICES);
        end else begin
            count = CW'(vertex_count_reg);
        end
        for (int j = 0; j < MAX_VERTICES; j++) begin
            count_mask[j] = (int'(count) > j);
        end
    end

    // Row and bit touched by the current pass of an edge write.
    assign ew_row = ew_phase_reg ? VW'(ew_to_reg) : VW'(ew_from_reg);
    assign ew_bit = ew_phase_reg ? VW'(ew_from_reg) : VW'(ew_to_reg);

    assign top_vertex = stack_reg[VW'(depth_reg - 1'b1)];
    assign ram_raddr  = (state_reg == S_E_RD || state_reg == S_E_WR) ? ew_row : top_vertex;
    assign ram_we     = (state_reg == S_E_WR);
    assign row_cur    = rd_valid_reg ? ram_rdata : '0;

    always_comb begin
        row_new         = row_cur;
        row_new[ew_bit] = ew_set_reg;
    end

    amdfs_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_matrix (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ew_row),
        .wdata (row_new),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Unvisited neighbours of the vertex on top of the stack.
    assign cand = row_cur & ~visited_reg & count_mask;

    amdfs_scan #(
        .WIDTH (MAX_VERTICES)
    ) u_scan (
        .cand  (cand),
        .found (found),
        .index (scan_idx)
    );

    // A new visit may be recorded when the pending slot can move on.
    assign out_free   = !m_valid_reg || m_tready;
    assign emit_ok    = !pend_valid_reg || out_free;
    assign root_open  = (state_reg == S_ROOT) && (root_reg != count);
    assign root_visit = root_open && !visited_reg[VW'(root_reg)] && emit_ok;
    assign nb_visit   = (state_reg == S_SCAN) && found && emit_ok;
    assign pop        = (state_reg == S_SCAN) && !found;
    assign emit       = root_visit || nb_visit;
    assign emit_vertex = root_visit ? VW'(root_reg) : scan_idx;
    assign end_push   = (state_reg == S_END) && pend_valid_reg && out_free;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == CMD_START) begin
                        state_next = S_ROOT;
                    end else if (in_range) begin
                        state_next = S_E_RD;
                    end
                end
            end
            S_E_RD: begin
                state_next = S_E_WR;
            end
            S_E_WR: begin
                state_next = (ew_mirror_reg && !ew_phase_reg) ? S_E_RD : S_IDLE;
            end
            S_ROOT: begin
                if (root_reg == count) begin
                    state_next = S_END;
                end else if (root_visit) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (nb_visit) begin
                    state_next = S_RD;
                end else if (pop) begin
                    state_next = (depth_reg == CW'(1)) ? S_ROOT : S_RD;
                end
            end
            S_END: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            vertex_count_reg <= VERTEX_COUNT_RST;
            directed_reg     <= DIRECTED_RST;
            row_valid_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            visited_reg      <= '0;
            depth_reg        <= '0;
            root_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            ew_phase_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= row_valid_reg[ram_raddr];

            if (cfg_we) begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: vertex_count_reg <= cfg_wdata;
                    CFG_DIRECTED:     directed_reg     <= cfg_wdata[0];
                    default:          ;
                endcase
            end

            if (in_acc) begin
                ew_phase_reg <= 1'b0;
            end else if (state_reg == S_E_WR) begin
                ew_phase_reg <= 1'b1;
            end
            if (ram_we) begin
                row_valid_reg[ew_row] <= 1'b1;
            end

            // Start of a walk clears the marks and the stack.
            if (in_acc && s_tuser == CMD_START) begin
                visited_reg    <= '0;
                depth_reg      <= '0;
                root_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end else begin
                if (root_open && (visited_reg[VW'(root_reg)] || emit_ok)) begin
                    root_reg <= root_reg + 1'b1;
                end
                if (emit) begin
                    visited_reg[emit_vertex] <= 1'b1;
                    pend_valid_reg           <= 1'b1;
                end else if (end_push) begin
                    pend_valid_reg <= 1'b0;
                end
                if (root_visit) begin
                    depth_reg <= CW'(1);
                end else if (nb_visit) begin
                    depth_reg <= depth_reg + 1'b1;
                end else if (pop) begin
                    depth_reg <= depth_reg - 1'b1;
                end
            end

            if ((emit && pend_valid_reg) || end_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            ew_from_reg   <= s_tdata[4:0];
            ew_to_reg     <= s_tdata[9:5];
            ew_set_reg    <= s_tdata[10];
            ew_mirror_reg <= !directed_reg;
        end
        if (root_visit) begin
            stack_reg[0] <= VW'(root_reg);
        end else if (nb_visit) begin
            stack_reg[VW'(depth_reg)] <= scan_idx;
        end
        if (emit) begin
            pend_vertex_reg <= emit_vertex;
            pend_root_reg   <= root_visit;
        end
        if ((emit && pend_valid_reg) || end_push) begin
            m_vertex_reg   <= VERTEX_W'(pend_vertex_reg);
            m_new_tree_reg <= pend_root_reg;
            m_last_reg     <= (state_reg == S_END);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_vertex_reg);
    assign m_tuser  = m_new_tree_reg;
    assign m_tlast  = m_last_reg;

    // The stack never holds more vertices than are in use.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= count)
        else $error("stack deeper than vertex count");

    // A neighbour pushed on the stack was not visited before.
    a_fresh_push: assert property (@(posedge aclk) disable iff (!aresetn)
        nb_visit |-> !visited_reg[scan_idx])
        else $error("visited vertex pushed again");

    // Row reads and scans only happen with a vertex on the stack.
    a_stack_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD || state_reg == S_SCAN) |-> depth_reg != '0)
        else $error("scan with empty stack");

    // Closing a walk with a pending visit puts out a final item.
    a_last_out: assert property (@(posedge aclk) disable iff (!aresetn)
        end_push |=> (m_tvalid && m_tlast))
        else $error("final visit not flagged");

endmodule
